### hw/rtl/vclw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vclw_pkg
// Shared types, constants and helpers for the vertex colour lift-to-white core.
// ----------------------------------------------------------------------------
package vclw_pkg;

    localparam int WORD_W    = 32;
    localparam int PCT_W     = 7;
    localparam int FMT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W    = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_PERCENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd1;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // floor(n/100) == (n*RECIP) >> RECIP_SHIFT, exact for n < 43690
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam int KP_W  = 20;            // 100*RECIP fits
    localparam int KC_W  = 28;            // (255*100+50)*RECIP fits
    localparam int MR_W  = 21;            // 255*RECIP fits
    localparam int SUM_W = KC_W + 1;
    localparam int QUO_W = SUM_W - RECIP_SHIFT;

    localparam logic [CHAN_W-1:0] MAX8 = 8'hFF;
    localparam logic [CHAN_W-1:0] MAX6 = 8'h3F;
    localparam logic [CHAN_W-1:0] MAX5 = 8'h1F;
    localparam logic [CHAN_W-1:0] MAX4 = 8'h0F;

    localparam logic [MR_W-1:0] MREC8 = MR_W'(255 * RECIP);
    localparam logic [MR_W-1:0] MREC6 = MR_W'(63 * RECIP);
    localparam logic [MR_W-1:0] MREC5 = MR_W'(31 * RECIP);
    localparam logic [MR_W-1:0] MREC4 = MR_W'(15 * RECIP);

    localparam logic [KC_W-1:0] HALF_REC = KC_W'(50 * RECIP);
    localparam logic [KP_W-1:0] KP_RESET = KP_W'(100 * RECIP);

    typedef enum logic [FMT_W-1:0] {
        FMT_RGBA8   = 3'd0,
        FMT_RGB8    = 3'd1,
        FMT_RGB565  = 3'd2,
        FMT_RGBA4   = 3'd3,
        FMT_RGBA6   = 3'd4,
        FMT_UNKNOWN = 3'd5
    } fmt_e;

    // Blend coefficients, pre-scaled by the reciprocal of 100
    typedef struct packed {
        logic            pass;
        logic [FMT_W-1:0] fmt;
        logic [KP_W-1:0] kp;
        logic [KC_W-1:0] kc8;
        logic [KC_W-1:0] kc6;
        logic [KC_W-1:0] kc5;
        logic [KC_W-1:0] kc4;
    } cfg_t;

    // (M*(100-p) + 50) * RECIP, with M*RECIP given
    function automatic logic [KC_W-1:0] kc_calc(
        input logic [PCT_W-1:0] psat,
        input logic [MR_W-1:0]  mrec
    );
        logic [PCT_W-1:0] inv;
        logic [KC_W-1:0]  prod;
        inv  = PCT_FULL - psat;
        prod = KC_W'(inv) * KC_W'(mrec);
        return prod + HALF_REC;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/vclw_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vclw_cfg
// Configuration registers; blend coefficients are worked out on the write.
// ----------------------------------------------------------------------------
module vclw_cfg
    import vclw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PCT_W-1:0]     cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [PCT_W-1:0] psat;

    // anything above 100 saturates
    assign psat = (cfg_wdata > PCT_FULL) ? PCT_FULL : cfg_wdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we && cfg_index == REG_BLEND_PERCENT)
        begin
            cfg_next.pass = (psat == PCT_FULL);
            cfg_next.kp   = KP_W'(psat) * KP_W'(RECIP);
            cfg_next.kc8  = kc_calc(psat, MREC8);
            cfg_next.kc6  = kc_calc(psat, MREC6);
            cfg_next.kc5  = kc_calc(psat, MREC5);
            cfg_next.kc4  = kc_calc(psat, MREC4);
        end
        else if (cfg_we && cfg_index == REG_PIXEL_FORMAT)
        begin
            cfg_next.fmt = cfg_wdata[FMT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pass <= 1'b1;
            cfg_reg.fmt  <= FMT_RGBA8;
            cfg_reg.kp   <= KP_RESET;
            cfg_reg.kc8  <= HALF_REC;
            cfg_reg.kc6  <= HALF_REC;
            cfg_reg.kc5  <= HALF_REC;
            cfg_reg.kc4  <= HALF_REC;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### hw/rtl/vclw_lift.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vclw_lift
// One channel: (v*p + M*(100-p) + 50) / 100 via a scaled reciprocal, capped.
// ----------------------------------------------------------------------------
module vclw_lift
    import vclw_pkg::*;
(
    input  wire logic [CHAN_W-1:0] chan_val,
    input  wire logic [CHAN_W-1:0] chan_max,
    input  wire logic [KP_W-1:0]   kp,
    input  wire logic [KC_W-1:0]   kc,
    output logic      [CHAN_W-1:0] lifted
);

    logic [CHAN_W-1:0] vm;
    logic [KC_W-1:0]   prod;
    logic [SUM_W-1:0]  sum;
    logic [QUO_W-1:0]  quo;

    assign vm   = chan_val & chan_max;
    assign prod = KC_W'(vm) * KC_W'(kp);
    assign sum  = SUM_W'(prod) + SUM_W'(kc);
    assign quo  = sum[SUM_W-1:RECIP_SHIFT];

    assign lifted = (quo > QUO_W'(chan_max)) ? chan_max : quo[CHAN_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/vclw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vclw_datapath
// Unpacks R, G and B by format, lifts each channel and repacks the word.
// ----------------------------------------------------------------------------
module vclw_datapath
    import vclw_pkg::*;
(
    input  wire logic [WORD_W-1:0] word_in,
    input  wire cfg_t              cfg,
    output logic      [WORD_W-1:0] word_out
);

    logic [CHAN_W-1:0] v_r, v_g, v_b;
    logic [CHAN_W-1:0] m_r, m_g, m_b;
    logic [KC_W-1:0]   kc_r, kc_g, kc_b;
    logic [CHAN_W-1:0] l_r, l_g, l_b;

    always_comb
    begin
        v_r  = '0;
        v_g  = '0;
        v_b  = '0;
        m_r  = MAX8;
        m_g  = MAX8;
        m_b  = MAX8;
        kc_r = cfg.kc8;
        kc_g = cfg.kc8;
        kc_b = cfg.kc8;
        unique case (cfg.fmt)
            FMT_RGBA8:
            begin
                v_r = word_in[31:24];
                v_g = word_in[23:16];
                v_b = word_in[15:8];
            end
            FMT_RGB8:
            begin
                v_r = word_in[23:16];
                v_g = word_in[15:8];
                v_b = word_in[7:0];
            end
            FMT_RGB565:
            begin
                v_r  = CHAN_W'(word_in[15:11]);
                v_g  = CHAN_W'(word_in[10:5]);
                v_b  = CHAN_W'(word_in[4:0]);
                m_r  = MAX5;
                m_g  = MAX6;
                m_b  = MAX5;
                kc_r = cfg.kc5;
                kc_g = cfg.kc6;
                kc_b = cfg.kc5;
            end
            FMT_RGBA4:
            begin
                v_r  = CHAN_W'(word_in[15:12]);
                v_g  = CHAN_W'(word_in[11:8]);
                v_b  = CHAN_W'(word_in[7:4]);
                m_r  = MAX4;
                m_g  = MAX4;
                m_b  = MAX4;
                kc_r = cfg.kc4;
                kc_g = cfg.kc4;
                kc_b = cfg.kc4;
            end
            FMT_RGBA6:
            begin
                v_r  = CHAN_W'(word_in[23:18]);
                v_g  = CHAN_W'(word_in[17:12]);
                v_b  = CHAN_W'(word_in[11:6]);
                m_r  = MAX6;
                m_g  = MAX6;
                m_b  = MAX6;
                kc_r = cfg.kc6;
                kc_g = cfg.kc6;
                kc_b = cfg.kc6;
            end
            default:
            begin
                v_r = '0;
            end
        endcase
    end

    vclw_lift u_lift_r (.chan_val(v_r), .chan_max(m_r), .kp(cfg.kp), .kc(kc_r), .lifted(l_r));
    vclw_lift u_lift_g (.chan_val(v_g), .chan_max(m_g), .kp(cfg.kp), .kc(kc_g), .lifted(l_g));
    vclw_lift u_lift_b (.chan_val(v_b), .chan_max(m_b), .kp(cfg.kp), .kc(kc_b), .lifted(l_b));

    always_comb
    begin
        word_out = word_in;
        if (!cfg.pass)
        begin
            unique case (cfg.fmt)
                FMT_RGBA8:  word_out = {l_r, l_g, l_b, word_in[7:0]};
                FMT_RGB8:   word_out = {word_in[31:24], l_r, l_g, l_b};
                FMT_RGB565: word_out = {word_in[31:16], l_r[4:0], l_g[5:0], l_b[4:0]};
                FMT_RGBA4:  word_out = {word_in[31:16], l_r[3:0], l_g[3:0], l_b[3:0],
                                        word_in[3:0]};
                FMT_RGBA6:  word_out = {word_in[31:24], l_r[5:0], l_g[5:0], l_b[5:0],
                                        word_in[5:0]};
                default:    word_out = word_in;
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/vertex_color_lerp_to_white_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_color_lerp_to_white_core
// Lifts the R, G and B channels of a packed vertex colour toward white.
// ----------------------------------------------------------------------------
// A start beat reaches the done strobe through the input register, then the result register.
// Throughput: one beat per cycle; busy is never raised.
// The receiver cannot stall: each result shows on patched_word with done high for one cycle.
// Reset (rst_n low, async): pipeline emptied, blend_percent = 100, format RGBA8.
// ----------------------------------------------------------------------------
module vertex_color_lerp_to_white_core
    import vclw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [WORD_W-1:0]    color_word,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PCT_W-1:0]     cfg_wdata,
    // results
    output logic                      done,
    output logic      [WORD_W-1:0]    patched_word
);

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              res_valid_reg;
    logic [WORD_W-1:0] res_word_reg;
    logic [WORD_W-1:0] res_word_next;

    // Coefficients are recomputed on each write so the datapath only sees
    // one multiply per channel: v * (p*RECIP) + (M*(100-p)+50)*RECIP.
    vclw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Fully pipelined; nothing ever backs up.
    assign busy = 1'b0;

    // Input register: the beat is taken on start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_word_reg <= color_word;
        end
    end

    // Unpack, blend and repack in one pass.
    vclw_datapath u_datapath (
        .word_in  (in_word_reg),
        .cfg      (cfg),
        .word_out (res_word_next)
    );

    // Result register: strobe for exactly one cycle per beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_word_reg <= res_word_next;
        end
    end

    assign done         = res_valid_reg;
    assign patched_word = res_word_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------

    // every accepted beat yields a result through the input and result registers
    a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted beat produced no result");

    // no result without a matching earlier beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without an accepted beat");

    // full percentage leaves the word untouched
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cfg.pass) |-> (patched_word == $past(color_word, 2)))
        else $error("word altered at full percentage");

endmodule
`default_nettype wire
